@@ rtl/core/alid_pkg.sv @@
package alid_pkg;

  // Sizing defaults
  localparam int unsigned DEPTH_DEF   = 16;
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned QUEUE_DEPTH = 2;

  // Input function codes
  localparam logic [2:0] FUNC_APPEND    = 3'd0;
  localparam logic [2:0] FUNC_INSERT_AT = 3'd1;
  localparam logic [2:0] FUNC_REM_LAST  = 3'd2;
  localparam logic [2:0] FUNC_REM_AT    = 3'd3;
  localparam logic [2:0] FUNC_READ_ALL  = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_BADPOS = 2'd3;

  typedef enum logic [2:0] {
    OP_APPEND,
    OP_INSERT_AT,
    OP_REM_LAST,
    OP_REM_AT,
    OP_READ_ALL
  } op_e;

  typedef enum logic {
    BK_RUN,
    BK_READ
  } back_state_e;

  // Decoded request handed from front to back
  typedef struct packed {
    op_e                op;
    logic signed [31:0] value;
    logic [3:0]         pos;
  } cmd_t;

endpackage

@@ rtl/core/alid_front.sv @@
module alid_front import alid_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         func_i,
  input  logic signed [31:0] value_in_i,
  input  logic [3:0]         position_i,
  output logic               cmd_valid_o,
  output cmd_t               cmd_o,
  input  logic               cmd_pop_i
);

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          queue_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          known;
  logic          push;
  op_e           op;

  // Decode the function code; unknown codes are accepted and dropped
  always_comb begin
    known = 1'b1;
    op    = OP_APPEND;
    case (func_i)
      FUNC_APPEND:    op = OP_APPEND;
      FUNC_INSERT_AT: op = OP_INSERT_AT;
      FUNC_REM_LAST:  op = OP_REM_LAST;
      FUNC_REM_AT:    op = OP_REM_AT;
      FUNC_READ_ALL:  op = OP_READ_ALL;
      default:        known = 1'b0;
    endcase
  end

  assign in_ready_o  = (cnt_q != CW'(QUEUE_DEPTH));
  assign push        = in_valid_i && in_ready_o && known;
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = queue_q[rd_ptr_q];

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (cmd_pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push && !cmd_pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (!push && cmd_pop_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Hold queued requests
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= '{op: op, value: value_in_i, pos: position_i};
    end
  end

endmodule

@@ rtl/core/alid_back.sv @@
module alid_back import alid_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  cmd_t               cmd_i,
  output logic               cmd_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] value_out_o,
  output logic [3:0]         entry_index_o,
  output logic [1:0]         status_o,
  output logic               last_o
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned WW = CW + 4;

  logic signed [31:0] entries_q [DEPTH];
  logic signed [31:0] entries_d [DEPTH];
  logic [CW-1:0]      count_q, count_d;
  back_state_e        state_q, state_d;
  logic [IW-1:0]      rd_idx_q, rd_idx_d;

  logic               out_valid_q, out_valid_d;
  logic signed [31:0] value_q, value_d;
  logic [3:0]         index_q, index_d;
  logic [1:0]         status_q, status_d;
  logic               last_q, last_d;

  logic               out_free;
  logic [WW-1:0]      count_w, pos_w, cm1_w, rn_w, rd_w;
  logic               full, empty;

  assign out_free = !out_valid_q || out_ready_i;
  assign count_w  = {4'b0, count_q};
  assign pos_w    = {{CW{1'b0}}, cmd_i.pos};
  assign cm1_w    = count_w - WW'(1);
  assign rd_w     = {{(WW - IW){1'b0}}, rd_idx_q};
  assign full     = (count_w >= WW'(DEPTH));
  assign empty    = (count_q == '0);
  assign rn_w     = (count_w > WW'(MAX_RESULTS)) ? WW'(MAX_RESULTS) : count_w;

  // Carry out one request, or give the next entry of a read out
  always_comb begin
    entries_d   = entries_q;
    count_d     = count_q;
    state_d     = state_q;
    rd_idx_d    = rd_idx_q;
    cmd_pop_o   = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    value_d     = value_q;
    index_d     = index_q;
    status_d    = status_q;
    last_d      = last_q;

    case (state_q)
      BK_RUN: begin
        if (cmd_valid_i && out_free) begin
          cmd_pop_o   = 1'b1;
          out_valid_d = 1'b1;
          value_d     = '0;
          index_d     = '0;
          status_d    = ST_OK;
          last_d      = 1'b1;
          case (cmd_i.op)
            OP_APPEND: begin
              if (full) begin
                status_d = ST_FULL;
              end else begin
                entries_d[count_w[IW-1:0]] = cmd_i.value;
                index_d = count_w[3:0];
                count_d = count_q + CW'(1);
              end
            end
            OP_INSERT_AT: begin
              if (full) begin
                status_d = ST_FULL;
              end else if (pos_w >= count_w) begin
                status_d = ST_BADPOS;
              end else begin
                // shift later entries up one place
                for (int i = 1; i < DEPTH; i++) begin
                  if (WW'(i) > pos_w && WW'(i) <= count_w) begin
                    entries_d[i] = entries_q[i-1];
                  end
                end
                entries_d[pos_w[IW-1:0]] = cmd_i.value;
                index_d = cmd_i.pos;
                count_d = count_q + CW'(1);
              end
            end
            OP_REM_LAST: begin
              if (empty) begin
                status_d = ST_EMPTY;
              end else begin
                value_d = entries_q[cm1_w[IW-1:0]];
                index_d = cm1_w[3:0];
                count_d = count_q - CW'(1);
              end
            end
            OP_REM_AT: begin
              if (empty) begin
                status_d = ST_EMPTY;
              end else if (pos_w >= count_w) begin
                status_d = ST_BADPOS;
              end else begin
                value_d = entries_q[pos_w[IW-1:0]];
                index_d = cmd_i.pos;
                // shift later entries down one place
                for (int i = 0; i < DEPTH - 1; i++) begin
                  if (WW'(i) >= pos_w) begin
                    entries_d[i] = entries_q[i+1];
                  end
                end
                count_d = count_q - CW'(1);
              end
            end
            OP_READ_ALL: begin
              if (empty) begin
                status_d = ST_EMPTY;
              end else begin
                value_d = entries_q[0];
                if (rn_w != WW'(1)) begin
                  last_d   = 1'b0;
                  state_d  = BK_READ;
                  rd_idx_d = IW'(1);
                end
              end
            end
            default: begin
              status_d = ST_OK;
            end
          endcase
        end
      end
      BK_READ: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          value_d     = entries_q[rd_idx_q];
          index_d     = rd_w[3:0];
          status_d    = ST_OK;
          last_d      = (rd_w + WW'(1) == rn_w);
          if (last_d) begin
            state_d = BK_RUN;
          end else begin
            rd_idx_d = rd_idx_q + IW'(1);
          end
        end
      end
      default: begin
        state_d = BK_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_RUN;
      count_q     <= '0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_idx_q    <= rd_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold list storage and the result register
  always_ff @(posedge clk_i) begin
    entries_q <= entries_d;
    value_q   <= value_d;
    index_q   <= index_d;
    status_q  <= status_d;
    last_q    <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign value_out_o   = value_q;
  assign entry_index_o = index_q;
  assign status_o      = status_q;
  assign last_o        = last_q;

endmodule

@@ rtl/core/array_list_insert_delete_core.sv @@
// With the queue empty and the result register free, an accepted request goes
// into the request queue register and then into the result register.
// Throughput: one request per cycle for append, insert, remove and error cases
// while the result register is free; shifts move all entries at once. A read
// out gives min(count, 16) entries one per cycle, paced by the result register.
// Reset clears the count, the two-entry request queue and the result valid;
// list storage is not cleared.
module array_list_insert_delete_core import alid_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         func_i,
  input  logic signed [31:0] value_in_i,
  input  logic [3:0]         position_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] value_out_o,
  output logic [3:0]         entry_index_o,
  output logic [1:0]         status_o,
  output logic               last_o
);

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  // Accept, decode and queue requests
  alid_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .value_in_i  (value_in_i),
    .position_i  (position_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // Execute requests against the list
  alid_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd),
    .cmd_pop_o     (cmd_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .value_out_o   (value_out_o),
    .entry_index_o (entry_index_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

endmodule
